FILE: design/esfr_pkg.sv
`default_nettype none
package esfr_pkg;

  // Frame buffer limit; a count that reaches it drops the frame.
  localparam int unsigned BUFFER_BYTES = 4096;
  localparam int unsigned COUNT_W      = $clog2(BUFFER_BYTES);

  localparam logic [7:0] START_BYTE  = 8'h5A;
  localparam logic [7:0] ESCAPE_BYTE = 8'hEF;
  localparam logic [7:0] ANY_TYPE    = 8'h00;

  localparam int unsigned MIN_FRAME = 4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] position;
    logic        frame_done;
    logic [12:0] frame_length;
    logic        overflow;
  } result_t;

endpackage
`default_nettype wire

FILE: design/esfr_cfg_if.sv
`default_nettype none
interface esfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] accept_type;

  modport source (output valid, output accept_type, input ready);
  modport sink (input valid, input accept_type, output ready);
endinterface
`default_nettype wire

FILE: design/esfr_rx_if.sv
`default_nettype none
interface esfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: design/esfr_res_if.sv
`default_nettype none
interface esfr_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [11:0] position;
  logic        frame_done;
  logic [12:0] frame_length;
  logic        overflow;

  modport source (output valid, output data_byte, output position, output frame_done,
                  output frame_length, output overflow, input ready);
  modport sink (input valid, input data_byte, input position, input frame_done,
                input frame_length, input overflow, output ready);
endinterface
`default_nettype wire

FILE: design/esfr_step.sv
`default_nettype none
module esfr_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  esfr_rx_if.sink                rx,
  input  wire logic [7:0]        accept_type_i,
  input  wire logic              res_ready_i,
  output logic                   res_valid_o,
  output esfr_pkg::result_t      res_o
);

  logic                          in_valid_q;
  logic [7:0]                    byte_q;
  logic [esfr_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                          esc_q, esc_d;
  logic [7:0]                    len_lo_q, len_lo_d;
  logic [7:0]                    len_hi_q, len_hi_d;
  logic [7:0]                    type_q, type_d;

  logic                          is_start, is_esc, is_ctrl, adv;
  logic [7:0]                    data_byte;
  logic [esfr_pkg::COUNT_W:0]    next_cnt;
  logic [15:0]                   want;
  logic                          ovf, done, type_ok;

  assign is_start = (byte_q == esfr_pkg::START_BYTE);
  assign is_esc   = (byte_q == esfr_pkg::ESCAPE_BYTE);
  assign is_ctrl  = is_start || is_esc;

  // Control bytes give no result, so they never wait for the output side.
  assign adv      = in_valid_q && (is_ctrl || res_ready_i);
  assign rx.ready = !in_valid_q || adv;

  assign data_byte = esc_q ? (byte_q + 8'd1) : byte_q;
  assign next_cnt  = {1'b0, count_q} + {{esfr_pkg::COUNT_W{1'b0}}, 1'b1};
  assign want      = {len_hi_q, len_lo_q};
  assign type_ok   = (accept_type_i == esfr_pkg::ANY_TYPE) || (accept_type_i == type_q);
  assign ovf       = (32'(next_cnt) >= 32'(esfr_pkg::BUFFER_BYTES));
  // Completion needs at least the header and one more byte, so the stored
  // header fields are always settled by the time they are compared.
  assign done      = !ovf && (32'(next_cnt) >= 32'(esfr_pkg::MIN_FRAME)) &&
                     (32'(next_cnt) == 32'(want)) && type_ok;

  always_comb begin
    count_d  = count_q;
    esc_d    = esc_q;
    len_lo_d = len_lo_q;
    len_hi_d = len_hi_q;
    type_d   = type_q;
    if (is_start) begin
      count_d = '0;
      esc_d   = 1'b0;
    end else if (is_esc) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      if (count_q == esfr_pkg::COUNT_W'(0)) len_lo_d = data_byte;
      if (count_q == esfr_pkg::COUNT_W'(1)) len_hi_d = data_byte;
      if (count_q == esfr_pkg::COUNT_W'(2)) type_d = data_byte;
      count_d = (ovf || done) ? '0 : next_cnt[esfr_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      count_q    <= '0;
      esc_q      <= 1'b0;
      len_lo_q   <= '0;
      len_hi_q   <= '0;
      type_q     <= '0;
    end else begin
      if (rx.ready) in_valid_q <= rx.valid;
      if (adv) begin
        count_q  <= count_d;
        esc_q    <= esc_d;
        len_lo_q <= len_lo_d;
        len_hi_q <= len_hi_d;
        type_q   <= type_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.ready && rx.valid) byte_q <= rx.rx_byte;
  end

  assign res_valid_o        = in_valid_q && !is_ctrl;
  assign res_o.data_byte    = data_byte;
  assign res_o.position     = 12'(count_q);
  assign res_o.frame_done   = done;
  assign res_o.frame_length = done ? 13'(next_cnt) : 13'd0;
  assign res_o.overflow     = ovf;

endmodule
`default_nettype wire

FILE: design/esfr_out_reg.sv
`default_nettype none
module esfr_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ld_valid_i,
  input  wire esfr_pkg::result_t ld_i,
  output logic                   ld_ready_o,
  esfr_res_if.source             res
);

  logic              valid_q;
  esfr_pkg::result_t data_q;

  // The register refills in the same cycle its beat is taken.
  assign ld_ready_o = !valid_q || res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld_ready_o) begin
      valid_q <= ld_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_ready_o && ld_valid_i) data_q <= ld_i;
  end

  assign res.valid        = valid_q;
  assign res.data_byte    = data_q.data_byte;
  assign res.position     = data_q.position;
  assign res.frame_done   = data_q.frame_done;
  assign res.frame_length = data_q.frame_length;
  assign res.overflow     = data_q.overflow;

endmodule
`default_nettype wire

FILE: design/escaped_serial_frame_receiver_unit.sv
`default_nettype none
// Channel  Dir  Payload                                              Handshake
// cfg_i    in   accept_type[7:0]                                     valid/ready
// rx_i     in   rx_byte[7:0]                                         valid/ready
// res_o    out  data_byte, position, frame_done, frame_length, overflow  valid/ready
//
// One byte per cycle while the output register can take results: a byte is registered at
// the edge that accepts it, decoded against the frame state from that register, and its
// result is loaded into the output register, from which the result beat is offered.
// Start and escape bytes update the state and produce no result beat.
// Reset clears the frame count, escape flag, header bytes and the type filter.
// A stalled output holds its beat; new bytes keep flowing while the output
// register can refill in the same cycle, and control bytes never wait on it.
module escaped_serial_frame_receiver_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  esfr_cfg_if.sink   cfg_i,
  esfr_rx_if.sink    rx_i,
  esfr_res_if.source res_o
);

  logic [7:0]        accept_type_q;
  logic              step_valid;
  logic              out_ready;
  esfr_pkg::result_t step_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_type_q <= esfr_pkg::ANY_TYPE;
    end else if (cfg_i.valid) begin
      accept_type_q <= cfg_i.accept_type;
    end
  end

  esfr_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx            (rx_i),
    .accept_type_i (accept_type_q),
    .res_ready_i   (out_ready),
    .res_valid_o   (step_valid),
    .res_o         (step_res)
  );

  esfr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_valid_i (step_valid),
    .ld_i       (step_res),
    .ld_ready_o (out_ready),
    .res        (res_o)
  );

endmodule
`default_nettype wire

FILE: sim/escaped_serial_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps

module escaped_serial_frame_receiver_unit_tb;

  localparam int HANG_LIMIT  = 5000;
  localparam int DRAIN_SLACK = 8;
  localparam int HOLD_OFF    = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  esfr_cfg_if cfg_ch ();
  esfr_rx_if  rx_ch ();
  esfr_res_if res_ch ();

  escaped_serial_frame_receiver_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Deframer state as the block should hold it.
  logic [12:0] frame_count  = '0;
  logic        escape_armed = 1'b0;
  logic [7:0]  hdr_len_lo   = '0;
  logic [7:0]  hdr_len_hi   = '0;
  logic [7:0]  hdr_type     = '0;
  logic [7:0]  type_filter  = esfr_pkg::ANY_TYPE;

  esfr_pkg::result_t expected_beats[$];
  esfr_pkg::result_t got_beat;
  esfr_pkg::result_t want_beat;

  int mismatches     = 0;
  int bytes_sent     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_cycles    = 0;
  int quiet_cycles   = 0;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void deframe_byte(input logic [7:0] raw);
    logic [7:0]        value;
    logic [12:0]       next_count;
    esfr_pkg::result_t beat;
    value = raw;
    if (raw == esfr_pkg::START_BYTE) begin
      frame_count  = '0;
      escape_armed = 1'b0;
      return;
    end
    if (raw == esfr_pkg::ESCAPE_BYTE) begin
      escape_armed = 1'b1;
      return;
    end
    if (escape_armed) begin
      value        = raw + 8'd1;
      escape_armed = 1'b0;
    end
    case (frame_count)
      13'd0: hdr_len_lo = value;
      13'd1: hdr_len_hi = value;
      13'd2: hdr_type   = value;
      default: ;
    endcase
    next_count     = frame_count + 13'd1;
    beat           = '0;
    beat.data_byte = value;
    beat.position  = frame_count[11:0];
    // The buffer limit wins over a length match at the same count.
    if (next_count >= esfr_pkg::BUFFER_BYTES) begin
      beat.overflow = 1'b1;
      next_count    = '0;
    end else if (next_count >= esfr_pkg::MIN_FRAME
                 && {3'b000, next_count} == {hdr_len_hi, hdr_len_lo}
                 && (type_filter == esfr_pkg::ANY_TYPE || type_filter == hdr_type)) begin
      beat.frame_done   = 1'b1;
      beat.frame_length = next_count;
      next_count        = '0;
    end
    frame_count = next_count;
    expected_beats.push_back(beat);
  endfunction

  // Rx beat: optional idle cycles, then valid stays up until accepted.
  task automatic send_byte(input logic [7:0] raw);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= raw;
    do @(posedge clk_i); while (!rx_ch.ready);
    bytes_sent++;
    deframe_byte(raw);
  endtask

  // Sends one frame byte, stuffing control values and now and then a plain value.
  task automatic send_data(input logic [7:0] value);
    if (value == esfr_pkg::START_BYTE || value == esfr_pkg::ESCAPE_BYTE
        || ($urandom_range(9) == 0 && value != esfr_pkg::START_BYTE + 8'd1
            && value != esfr_pkg::ESCAPE_BYTE + 8'd1)) begin
      send_byte(esfr_pkg::ESCAPE_BYTE);
      send_byte(value - 8'd1);
    end else begin
      send_byte(value);
    end
  endtask

  // A start byte, then the first sent_bytes bytes of header plus random body.
  task automatic send_frame(input int sent_bytes, input logic [15:0] len_field,
                            input logic [7:0] ftype);
    send_byte(esfr_pkg::START_BYTE);
    for (int i = 0; i < sent_bytes; i++) begin
      case (i)
        0: send_data(len_field[7:0]);
        1: send_data(len_field[15:8]);
        2: send_data(ftype);
        default: send_data(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    // Control bytes leave no result, so give the pipeline time to settle.
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_type_filter(input logic [7:0] value);
    wait_drained();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.accept_type <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    type_filter = value;
  endtask

  task automatic test_escapes();
    write_type_filter(esfr_pkg::ANY_TYPE);
    send_byte(esfr_pkg::START_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(esfr_pkg::ESCAPE_BYTE);
    send_byte(8'hFF);
    // A second escape leaves the flag set.
    send_byte(esfr_pkg::ESCAPE_BYTE);
    send_byte(esfr_pkg::ESCAPE_BYTE);
    send_byte(8'h10);
    // A start byte cancels a pending escape.
    send_byte(esfr_pkg::ESCAPE_BYTE);
    send_byte(esfr_pkg::START_BYTE);
    send_byte(8'h7F);
    send_byte(esfr_pkg::ESCAPE_BYTE);
    send_byte(esfr_pkg::START_BYTE - 8'd1);
    send_byte(esfr_pkg::ESCAPE_BYTE);
    send_byte(esfr_pkg::ESCAPE_BYTE - 8'd1);
    send_byte(8'h80);
  endtask

  task automatic test_frame_completion();
    send_frame(4, 16'd4, 8'h07);
    // After a completed frame, bytes without a start begin a new frame.
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h09);
    send_byte(8'h01);
    send_byte(8'h02);
    // A length below the minimum never completes.
    send_frame(6, 16'd2, 8'h01);
  endtask

  task automatic test_type_filter();
    write_type_filter(8'hFF);
    send_frame(4, 16'd4, 8'hFF);
    send_frame(4, 16'd4, 8'h01);
    write_type_filter(esfr_pkg::START_BYTE);
    send_frame(5, 16'd5, esfr_pkg::START_BYTE);
    send_frame(5, 16'd5, esfr_pkg::ANY_TYPE);
  endtask

  task automatic test_buffer_limit();
    write_type_filter(esfr_pkg::ANY_TYPE);
    // A frame as long as the buffer overflows instead of completing.
    send_frame(esfr_pkg::BUFFER_BYTES, 16'(esfr_pkg::BUFFER_BYTES), esfr_pkg::ANY_TYPE);
    send_data(8'h33);
    send_data(8'h44);
    send_frame(esfr_pkg::BUFFER_BYTES - 1, 16'(esfr_pkg::BUFFER_BYTES - 1), 8'h21);
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = HOLD_OFF;
    repeat (3) send_frame(30, 16'd30, 8'h02);
    wait_drained();
    send_frame(12, 16'd12, 8'h03);
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input logic [7:0] filter, input int n_items);
    int          stop_at;
    int          kind;
    int          total;
    logic [15:0] bad_len;
    logic [7:0]  ftype;
    write_type_filter(filter);
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    stop_at        = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      kind  = $urandom_range(99);
      total = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(4, 16);
      ftype = (filter == esfr_pkg::ANY_TYPE || $urandom_range(3) == 0)
              ? 8'($urandom_range(255)) : filter;
      if (kind < 70) begin
        send_frame(total, 16'(total), ftype);
      end else if (kind < 80) begin
        case ($urandom_range(2))
          0: bad_len = 16'($urandom_range(3));
          1: bad_len = 16'(total + $urandom_range(1, 4));
          default: bad_len = 16'($urandom_range(65535));
        endcase
        send_frame(total, bad_len, ftype);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
      end else begin
        send_frame($urandom_range(1, total - 1), 16'(total), ftype);
        if ($urandom_range(1)) send_byte(esfr_pkg::ESCAPE_BYTE);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got_beat.data_byte    = res_ch.data_byte;
      got_beat.position     = res_ch.position;
      got_beat.frame_done   = res_ch.frame_done;
      got_beat.frame_length = res_ch.frame_length;
      got_beat.overflow     = res_ch.overflow;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %p", got_beat));
      end else begin
        want_beat = expected_beats.pop_front();
        if (got_beat.data_byte != want_beat.data_byte)
          report_mismatch($sformatf("data_byte %h, want %h",
                                    got_beat.data_byte, want_beat.data_byte));
        if (got_beat.position != want_beat.position)
          report_mismatch($sformatf("position %0d, want %0d",
                                    got_beat.position, want_beat.position));
        if (got_beat.frame_done != want_beat.frame_done)
          report_mismatch($sformatf("frame_done %b, want %b at position %0d",
                                    got_beat.frame_done, want_beat.frame_done,
                                    want_beat.position));
        if (got_beat.frame_length != want_beat.frame_length)
          report_mismatch($sformatf("frame_length %0d, want %0d",
                                    got_beat.frame_length, want_beat.frame_length));
        if (got_beat.overflow != want_beat.overflow)
          report_mismatch($sformatf("overflow %b, want %b at position %0d",
                                    got_beat.overflow, want_beat.overflow,
                                    want_beat.position));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $realtime, HANG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rx_ch.valid        = 1'b0;
    rx_ch.rx_byte      = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.accept_type = '0;
    res_ch.ready       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_escapes();
    test_frame_completion();
    test_type_filter();
    test_buffer_limit();
    test_backpressure();
    test_random_traffic(0, 0, esfr_pkg::ANY_TYPE, 310);
    test_random_traffic(68, 0, 8'hFF, 310);
    test_random_traffic(0, 68, 8'($urandom_range(1, 254)), 310);
    test_random_traffic(32, 32, esfr_pkg::ESCAPE_BYTE, 310);

    wait_drained();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
